### rtl/bbf_pkg.sv
// ----------------------------------------------------------------------------
// bbf_pkg
// Shared types and constants of the box blur filter.
// ----------------------------------------------------------------------------
package bbf_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_RADIUS   = 12;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int SLOTS        = 2 * MAX_RADIUS + 1;

   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int ADDR_W   = SLOT_W + COL_W;
   localparam int RAM_DEPTH = SLOTS * MAX_WIDTH;
   localparam int PIX_W    = 24;

   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 13;
   localparam int RADIUS_W = 4;
   localparam int IN_ROW_W = 13;
   localparam int OUT_ROW_W = 12;
   localparam int LAG_W    = 15;
   localparam int SIDE_W   = 5;
   localparam int AREA_W   = 10;
   localparam int SUM_W    = 18;
   localparam int CNT_W    = 5;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd2;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd1;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic       flush;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic start;
      logic step;
      logic div_load;
      logic div_step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic has_result;
      logic sweep_last;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

### rtl/box_blur_filter_top.sv
// ----------------------------------------------------------------------------
// box_blur_filter_top
// Streaming RGB box blur over a (2r+1) x (2r+1) window.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; each output is the truncated per-channel mean
// of its window, or the pixel itself within r of an edge. Outputs trail the
// input by r rows plus r pixels, so after a frame r*width+r flush transfers
// drain it. An input transfer that yields an output starts a sweep: the
// window is read one pixel a cycle through the single read port of the line
// store, then divided by the area in an 18-step serial divider, and no new
// input is taken until the result is loaded into the output register.
// A configuration write restarts the frame.
module box_blur_filter_top
   import bbf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   bbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bbf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

### rtl/bbf_ram.sv
// ----------------------------------------------------------------------------
// bbf_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bbf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bbf_ctrl.sv
// ----------------------------------------------------------------------------
// bbf_ctrl
// Sequencer: accept, window sweep, serial divide, result hand-off.
// ----------------------------------------------------------------------------
module bbf_ctrl
   import bbf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SWEEP    = 6'b000010,
      ST_DRAIN    = 6'b000100,
      ST_DIV_LOAD = 6'b001000,
      ST_DIVIDE   = 6'b010000,
      ST_HOLD     = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && sts.has_result) begin
               cmd.start = 1'b1;
               state_in  = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cmd.step = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

### rtl/bbf_datapath.sv
// ----------------------------------------------------------------------------
// bbf_datapath
// Line store, position counters, window accumulator, divider, output register.
// ----------------------------------------------------------------------------
module bbf_datapath
   import bbf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   output rsp_type               rsp_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output sts_type               sts
);

   // configuration
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic                cfg_hit;

   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [RADIUS_W-1:0] r_eff;
   logic [LAG_W-1:0]    lag;

   // positions
   logic [COL_W-1:0]     in_col_ff, in_col_in;
   logic [IN_ROW_W-1:0]  in_row_ff, in_row_in;
   logic [SLOT_W-1:0]    in_slot_ff, in_slot_in;
   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [OUT_ROW_W-1:0] out_row_ff, out_row_in;
   logic [SLOT_W-1:0]    out_slot_ff, out_slot_in;
   logic [LAG_W-1:0]     tick_ff, tick_in;

   // sweep
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [COL_W-1:0]  rd_col_ff, rd_col_in;
   logic [SLOT_W-1:0] base_slot_ff, base_slot_in;
   logic [COL_W-1:0]  base_col_ff, base_col_in;
   logic [SIDE_W-1:0] dx_ff, dx_in;
   logic [SIDE_W-1:0] dy_ff, dy_in;
   logic [SIDE_W-1:0] lim_ff, lim_in;
   logic              acc_en_ff;

   // accumulate and divide, one lane per channel
   logic [SUM_W-1:0]  sum_ff [3];
   logic [SUM_W-1:0]  sum_in [3];
   logic [AREA_W-1:0] rem_ff [3];
   logic [AREA_W-1:0] rem_in [3];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [AREA_W:0]   rem_shift [3];
   logic [SIDE_W-1:0] side;
   logic [AREA_W-1:0] area;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic accepting;
   logic drop;
   logic is_edge;
   logic out_last;
   logic restart;
   logic [SLOT_W:0] slot_wrap;

   logic              wr_en;
   logic [PIX_W-1:0]  rd_data;
   logic [7:0]        chan [3];

   assign w_eff = (width_ff == '0) ? WIDTH_W'(1) :
                  (width_ff > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff == '0) ? HEIGHT_W'(1) :
                  (height_ff > HEIGHT_W'(HEIGHT_LIMIT)) ? HEIGHT_W'(HEIGHT_LIMIT) : height_ff;
   assign r_eff = (radius_ff > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_ff;
   assign lag   = LAG_W'(r_eff) * LAG_W'(w_eff) + LAG_W'(r_eff);

   assign accepting = (in_row_ff < h_eff);
   assign drop      = req_data.flush && accepting;
   assign wr_en     = cmd.accept && accepting && !req_data.flush;

   assign is_edge = ({1'b0, out_col_ff} < WIDTH_W'(r_eff))
                 || (({1'b0, out_col_ff} + WIDTH_W'(r_eff)) >= w_eff)
                 || ({1'b0, out_row_ff} < HEIGHT_W'(r_eff))
                 || (({1'b0, out_row_ff} + HEIGHT_W'(r_eff)) >= h_eff);
   assign out_last = ({1'b0, out_row_ff} == (h_eff - HEIGHT_W'(1)))
                  && ({1'b0, out_col_ff} == (w_eff - WIDTH_W'(1)));

   assign side = lim_ff + SIDE_W'(1);
   assign area = AREA_W'(side) * AREA_W'(side);

   // window top row slot, wrapped around the line store
   assign slot_wrap = ({1'b0, out_slot_ff} >= (SLOT_W + 1)'(r_eff)) ?
                      ({1'b0, out_slot_ff} - (SLOT_W + 1)'(r_eff)) :
                      ({1'b0, out_slot_ff} + (SLOT_W + 1)'(SLOTS) - (SLOT_W + 1)'(r_eff));

   assign chan[0] = rd_data[23:16];
   assign chan[1] = rd_data[15:8];
   assign chan[2] = rd_data[7:0];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rem_shift[c] = {rem_ff[c], sum_ff[c][SUM_W-1]};
      end
   end

   assign restart = cfg_hit || (cmd.load && out_last);

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      radius_in    = radius_ff;
      cfg_hit      = 1'b0;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_slot_in   = in_slot_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_slot_in  = out_slot_ff;
      tick_in      = tick_ff;
      rd_slot_in   = rd_slot_ff;
      rd_col_in    = rd_col_ff;
      base_slot_in = base_slot_ff;
      base_col_in  = base_col_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      lim_in       = lim_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = sum_ff[c];
         rem_in[c] = rem_ff[c];
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH: begin
               width_in = csr_wdata[WIDTH_W-1:0];
               cfg_hit  = 1'b1;
            end
            CSR_HEIGHT: begin
               height_in = csr_wdata[HEIGHT_W-1:0];
               cfg_hit   = 1'b1;
            end
            CSR_RADIUS: begin
               radius_in = csr_wdata[RADIUS_W-1:0];
               cfg_hit   = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end

      if (cmd.accept && !drop) begin
         if (accepting) begin
            if (({1'b0, in_col_ff} + WIDTH_W'(1)) >= w_eff) begin
               in_col_in  = '0;
               in_row_in  = in_row_ff + IN_ROW_W'(1);
               in_slot_in = (in_slot_ff == SLOT_W'(SLOTS - 1)) ? '0 :
                            in_slot_ff + SLOT_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
         end
         if (tick_ff < lag) begin
            tick_in = tick_ff + LAG_W'(1);
         end
      end

      if (cmd.start) begin
         lim_in       = is_edge ? '0 : SIDE_W'({r_eff, 1'b0});
         base_slot_in = is_edge ? out_slot_ff : slot_wrap[SLOT_W-1:0];
         base_col_in  = is_edge ? out_col_ff : out_col_ff - COL_W'(r_eff);
         rd_slot_in   = base_slot_in;
         rd_col_in    = base_col_in;
         dx_in        = '0;
         dy_in        = '0;
         for (int c = 0; c < 3; c++) begin
            sum_in[c] = '0;
         end
      end

      if (cmd.step) begin
         if (dx_ff == lim_ff) begin
            dx_in      = '0;
            dy_in      = dy_ff + SIDE_W'(1);
            rd_col_in  = base_col_ff;
            rd_slot_in = (rd_slot_ff == SLOT_W'(SLOTS - 1)) ? '0 :
                         rd_slot_ff + SLOT_W'(1);
         end else begin
            dx_in     = dx_ff + SIDE_W'(1);
            rd_col_in = rd_col_ff + COL_W'(1);
         end
      end

      if (acc_en_ff) begin
         for (int c = 0; c < 3; c++) begin
            sum_in[c] = sum_ff[c] + SUM_W'(chan[c]);
         end
      end

      // restoring divide, quotient shifts into the sum register
      if (cmd.div_load) begin
         cnt_in = CNT_W'(SUM_W);
         for (int c = 0; c < 3; c++) begin
            rem_in[c] = '0;
         end
      end

      if (cmd.div_step) begin
         cnt_in = cnt_ff - CNT_W'(1);
         for (int c = 0; c < 3; c++) begin
            if (rem_shift[c] >= {1'b0, area}) begin
               rem_in[c] = AREA_W'(rem_shift[c] - {1'b0, area});
               sum_in[c] = {sum_ff[c][SUM_W-2:0], 1'b1};
            end else begin
               rem_in[c] = rem_shift[c][AREA_W-1:0];
               sum_in[c] = {sum_ff[c][SUM_W-2:0], 1'b0};
            end
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.red_out    = sum_ff[0][7:0];
         rsp_data_in.green_out  = sum_ff[1][7:0];
         rsp_data_in.blue_out   = sum_ff[2][7:0];
         rsp_data_in.frame_last = out_last;
         if (({1'b0, out_col_ff} + WIDTH_W'(1)) >= w_eff) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + OUT_ROW_W'(1);
            out_slot_in = (out_slot_ff == SLOT_W'(SLOTS - 1)) ? '0 :
                          out_slot_ff + SLOT_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end

      if (restart) begin
         in_col_in   = '0;
         in_row_in   = '0;
         in_slot_in  = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         out_slot_in = '0;
         tick_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         radius_ff    <= RADIUS_RESET;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         tick_ff      <= '0;
         acc_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         radius_ff    <= radius_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_slot_ff   <= in_slot_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_slot_ff  <= out_slot_in;
         tick_ff      <= tick_in;
         acc_en_ff    <= cmd.step;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff   <= rd_slot_in;
      rd_col_ff    <= rd_col_in;
      base_slot_ff <= base_slot_in;
      base_col_ff  <= base_col_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      lim_ff       <= lim_in;
      cnt_ff       <= cnt_in;
      rsp_data_ff  <= rsp_data_in;
      for (int c = 0; c < 3; c++) begin
         sum_ff[c] <= sum_in[c];
         rem_ff[c] <= rem_in[c];
      end
   end

   bbf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (RAM_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({in_slot_ff, in_col_ff}),
      .wr_data ({req_data.red_in, req_data.green_in, req_data.blue_in}),
      .rd_en   (cmd.step),
      .rd_addr ({rd_slot_ff, rd_col_ff}),
      .rd_data (rd_data)
   );

   assign sts.has_result = !drop && (tick_ff >= lag);
   assign sts.sweep_last = (dx_ff == lim_ff) && (dy_ff == lim_ff);
   assign sts.div_last   = (cnt_ff == CNT_W'(1));
   assign sts.out_free   = !rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/bbf_props.sv
// ----------------------------------------------------------------------------
// bbf_props
// Port-level assertions for the box blur filter, bound to the top level.
// ----------------------------------------------------------------------------
module bbf_props
   import bbf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // result holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // a result needs a whole sweep, never two back to back
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("result follows a transfer immediately");

   // out of reset the block is empty and ready
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not empty after reset");

   // no input is taken while a result is being worked
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid || !req_ready)
      else $error("result appeared with input side still open");

endmodule

bind box_blur_filter_top bbf_props u_props (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
